[design/daac_pkg.sv]
// Shared widths, types and constants of the dual actuator approach control.
package daac_pkg;

  // ADC reading width; the position and distance widths follow from it
  localparam int ADC_BITS = 12;

  localparam int TARGET_W = 9;
  localparam int TOL_W    = 10;
  localparam int COUNT_W  = 8;
  localparam int SLOW_W   = 11;
  localparam int SPEED_W  = 7;
  localparam int DRIVE_W  = 8;

  // adc * 1762 >> 10 minus 41 fits a signed word two bits wider than the ADC
  localparam int ADC_SCALE = 1762;
  localparam int SCALE_W   = 11;
  localparam int SCALE_SH  = 10;
  localparam int POS_OFS   = 41;
  localparam int PROD_W    = ADC_BITS + SCALE_W;
  localparam int POS_W     = ADC_BITS + 2;
  localparam int DIFF_W    = POS_W + 1;
  localparam int CMP_W     = DIFF_W + 1;

  // floor(x / 3) for a 7-bit x as (x * 43) >> 7
  localparam int THIRD_MUL = 43;
  localparam int THIRD_SH  = 7;
  localparam int THIRD_W   = 6;

  localparam logic [DRIVE_W-1:0] DRIVE_STOP = 8'd127;

  // Stream word layout
  localparam int IN_W       = 2 * TARGET_W + 2 * ADC_BITS;
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = 2 * DRIVE_W + 3;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = SLOW_W;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_TOL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_TOL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_MAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_SLOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_SLOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_SPEED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_SPEED = 3'd6;

  // Input command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic [TOL_W-1:0]   tol;
    logic [SLOW_W-1:0]  slow;
    logic [SPEED_W-1:0] speed;
  } axis_cfg_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic               active;
  } axis_res_t;

endpackage

[design/daac_axis.sv]
// One actuator channel: position, goal, settle counter and drive byte.
module daac_axis
  import daac_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                cmd_i,
  input  logic [TARGET_W-1:0] target_i,
  input  logic [ADC_BITS-1:0] adc_i,
  input  axis_cfg_t           cfg_i,
  input  logic [COUNT_W-1:0]  count_max_i,
  output axis_res_t           res_o
);

  logic signed [POS_W-1:0]  pos_q, pos_d, pos_new;
  logic [TARGET_W-1:0]      goal_q, goal_d;
  logic [COUNT_W-1:0]       cnt_q, cnt_d, cnt_upd;
  logic                     en_q, en_d, en_upd;

  logic signed [DIFF_W-1:0] diff_prev, diff_next;
  logic [DIFF_W-1:0]        dist_prev, dist_next;
  logic                     in_band;
  logic [PROD_W-1:0]        prod;
  logic [SPEED_W+THIRD_W-1:0] third_prod;
  logic [SPEED_W-1:0]       spd;
  logic                     near, mid;

  // settle check against the position held before this sample
  assign diff_prev = DIFF_W'(pos_q) - $signed(DIFF_W'({1'b0, goal_q}));
  assign dist_prev = diff_prev[DIFF_W-1] ? DIFF_W'(-diff_prev) : DIFF_W'(diff_prev);
  assign in_band   = CMP_W'(dist_prev) < CMP_W'(cfg_i.tol);

  always_comb begin
    if (!in_band) begin
      cnt_upd = '0;
    end else if (cnt_q == {COUNT_W{1'b1}}) begin
      cnt_upd = cnt_q;
    end else begin
      cnt_upd = cnt_q + COUNT_W'(1);
    end
  end

  assign en_upd = en_q & (cnt_upd < count_max_i);

  assign prod    = PROD_W'(adc_i) * PROD_W'(ADC_SCALE);
  assign pos_new = $signed(POS_W'(prod[PROD_W-1:SCALE_SH])) - POS_W'(POS_OFS);

  always_comb begin
    if (cmd_i == CMD_SAMPLE) begin
      pos_d  = pos_new;
      goal_d = goal_q;
      cnt_d  = cnt_upd;
      en_d   = en_upd;
    end else begin
      pos_d  = pos_q;
      goal_d = target_i;
      cnt_d  = '0;
      en_d   = 1'b1;
    end
  end

  // drive from the state after the update
  assign diff_next = DIFF_W'(pos_d) - $signed(DIFF_W'({1'b0, goal_d}));
  assign dist_next = diff_next[DIFF_W-1] ? DIFF_W'(-diff_next) : DIFF_W'(diff_next);
  assign near      = {dist_next, 1'b0} < CMP_W'(cfg_i.slow);
  assign mid       = CMP_W'(dist_next) < CMP_W'(cfg_i.slow);
  assign third_prod = (SPEED_W+THIRD_W)'(cfg_i.speed) * (SPEED_W+THIRD_W)'(THIRD_MUL);

  always_comb begin
    if (near) begin
      spd = SPEED_W'(third_prod[SPEED_W+THIRD_W-1:THIRD_SH]);
    end else if (mid) begin
      spd = SPEED_W'(cfg_i.speed[SPEED_W-1:1]);
    end else begin
      spd = cfg_i.speed;
    end
  end

  always_comb begin
    res_o.active = en_d;
    if (!en_d) begin
      res_o.drive = DRIVE_STOP;
    end else if (diff_next > 0) begin
      res_o.drive = DRIVE_STOP - DRIVE_W'(spd);
    end else begin
      res_o.drive = DRIVE_STOP + DRIVE_W'(spd);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      goal_q <= '0;
      cnt_q  <= '0;
      en_q   <= 1'b0;
    end else if (step_i) begin
      pos_q  <= pos_d;
      goal_q <= goal_d;
      cnt_q  <= cnt_d;
      en_q   <= en_d;
    end
  end

endmodule

[design/dual_actuator_approach_control_core.sv]
// Top level of the dual actuator approach control: stream ports, registers, result word.
//
// Each input word is one control tick for two linear actuators and yields one result word.
// A load command (tuser 0) sets both targets, enables both actuators and clears the settle
// counters; a sample command (tuser 1) counts in-band ticks against the previous position,
// disables an actuator once its count reaches the shared maximum, converts both ADC readings
// to positions in hundredths and computes the drive bytes (127 is stop). A word is taken
// in every cycle unless a result waits untaken: the whole update is one pass of short logic
// from the input port into the state and the output register, so the result appears in the
// cycle after acceptance, and the output register lets a new word in while the last is taken.
// Configuration writes take effect at the next clock edge and must be made while idle.
module dual_actuator_approach_control_core
  import daac_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [8:0] lower_target, [17:9] upper_target, [29:18] lower_adc, [41:30] upper_adc
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] command
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] lower_drive, [15:8] upper_drive, [16] lower_active, [17] upper_active,
  // [18] all_settled
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int LT_LO = 0;
  localparam int UT_LO = TARGET_W;
  localparam int LA_LO = 2 * TARGET_W;
  localparam int UA_LO = 2 * TARGET_W + ADC_BITS;

  logic [TOL_W-1:0]   lower_tol_q, upper_tol_q;
  logic [COUNT_W-1:0] count_max_q;
  logic [SLOW_W-1:0]  lower_slow_q, upper_slow_q;
  logic [SPEED_W-1:0] lower_speed_q, upper_speed_q;

  axis_cfg_t lower_cfg, upper_cfg;
  axis_res_t lower_res, upper_res;

  logic                   accept;
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_tol_q   <= 10'd5;
      upper_tol_q   <= 10'd5;
      count_max_q   <= 8'd10;
      lower_slow_q  <= 11'd50;
      upper_slow_q  <= 11'd50;
      lower_speed_q <= 7'd100;
      upper_speed_q <= 7'd100;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOWER_TOL:   lower_tol_q   <= cfg_wdata_i[TOL_W-1:0];
        REG_UPPER_TOL:   upper_tol_q   <= cfg_wdata_i[TOL_W-1:0];
        REG_COUNT_MAX:   count_max_q   <= cfg_wdata_i[COUNT_W-1:0];
        REG_LOWER_SLOW:  lower_slow_q  <= cfg_wdata_i[SLOW_W-1:0];
        REG_UPPER_SLOW:  upper_slow_q  <= cfg_wdata_i[SLOW_W-1:0];
        REG_LOWER_SPEED: lower_speed_q <= cfg_wdata_i[SPEED_W-1:0];
        REG_UPPER_SPEED: upper_speed_q <= cfg_wdata_i[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  assign lower_cfg = '{tol: lower_tol_q, slow: lower_slow_q, speed: lower_speed_q};
  assign upper_cfg = '{tol: upper_tol_q, slow: upper_slow_q, speed: upper_speed_q};

  // take a word whenever the output register is free or being drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  daac_axis u_lower (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .cmd_i       (s_axis_tuser),
    .target_i    (s_axis_tdata[LT_LO +: TARGET_W]),
    .adc_i       (s_axis_tdata[LA_LO +: ADC_BITS]),
    .cfg_i       (lower_cfg),
    .count_max_i (count_max_q),
    .res_o       (lower_res)
  );

  daac_axis u_upper (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .cmd_i       (s_axis_tuser),
    .target_i    (s_axis_tdata[UT_LO +: TARGET_W]),
    .adc_i       (s_axis_tdata[UA_LO +: ADC_BITS]),
    .cfg_i       (upper_cfg),
    .count_max_i (count_max_q),
    .res_o       (upper_res)
  );

  assign out_data_d = OUT_TDATA_W'({!lower_res.active && !upper_res.active,
                                    upper_res.active, lower_res.active,
                                    upper_res.drive, lower_res.drive});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  a_load_enables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (s_axis_tuser == CMD_LOAD) |=> m_axis_tdata[16] && m_axis_tdata[17]
                                             && !m_axis_tdata[18])
    else $error("load command did not enable both actuators");

  a_settled_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[18] == (!m_axis_tdata[16] && !m_axis_tdata[17])))
    else $error("all_settled disagrees with active flags");

  a_stop_lower: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[16] |-> m_axis_tdata[7:0] == DRIVE_STOP)
    else $error("disabled lower actuator not stopped");

  a_stop_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[17] |-> m_axis_tdata[15:8] == DRIVE_STOP)
    else $error("disabled upper actuator not stopped");

endmodule
